[rtl/core/dqe_pkg.sv]
`timescale 1ns / 1ps

package dqe_pkg;

	// Store geometry
	localparam int DQE_DEPTH = 64;
	localparam int DQE_IDX_W = $clog2(DQE_DEPTH);
	localparam int DQE_CNT_W = DQE_IDX_W + 1;
	localparam int DQE_ELEM_W = 32;
	localparam int DQE_POS_W = 6;

	// Operation codes carried in the mode field
	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_BACK   = 3'd2,
		MODE_POP_FRONT  = 3'd3,
		MODE_PEEK_BACK  = 3'd4,
		MODE_PEEK_FRONT = 3'd5,
		MODE_READ_POS   = 3'd6,
		MODE_CLEAR      = 3'd7
	} mode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]            mode;
		logic [DQE_ELEM_W-1:0] element;
		logic [DQE_POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [DQE_ELEM_W-1:0] value_out;
		logic [1:0]            status;
		logic [DQE_CNT_W-1:0]  occupancy;
	} rsp_t;

	// Controller to datapath command
	typedef struct packed {
		logic load;
	} dqe_cmd_t;

endpackage

[rtl/core/dqe_ctrl.sv]
`timescale 1ns / 1ps

module dqe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dqe_pkg::dqe_cmd_t cmd
);
	import dqe_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_OUT  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;

	// Take a transaction only while no result is pending
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign cmd.load  = req_valid && (state_q == S_IDLE);

	// Advance between accept and result hold
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_OUT;
			end
			S_OUT: begin
				if (!rsp_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/dqe_datapath.sv]
`timescale 1ns / 1ps

module dqe_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  dqe_pkg::dqe_cmd_t cmd,
	input  dqe_pkg::req_t     req,
	output dqe_pkg::rsp_t     rsp
);
	import dqe_pkg::*;

	logic [DQE_ELEM_W-1:0] mem [DQE_DEPTH];

	logic [DQE_IDX_W-1:0]  front_q;
	logic [DQE_CNT_W-1:0]  count_q;
	logic [DQE_ELEM_W-1:0] rd_data_q;
	logic                  has_value_q;
	status_t               status_q;

	logic [DQE_IDX_W-1:0]  front_d;
	logic [DQE_CNT_W-1:0]  count_d;
	logic [DQE_IDX_W-1:0]  rd_addr;
	logic [DQE_IDX_W-1:0]  wr_addr;
	logic                  wr_en;
	logic                  has_value;
	status_t               status_d;
	logic                  full;
	logic                  empty;
	logic [DQE_IDX_W-1:0]  back_idx;
	logic [DQE_IDX_W-1:0]  tail_idx;
	logic [DQE_IDX_W-1:0]  prev_front;
	logic [DQE_IDX_W-1:0]  next_front;
	logic [DQE_IDX_W-1:0]  pos_idx;
	logic [DQE_CNT_W-1:0]  pos_ext;

	// Ring arithmetic wraps in the index width
	assign full       = (count_q == DQE_CNT_W'(DQE_DEPTH));
	assign empty      = (count_q == '0);
	assign tail_idx   = front_q + count_q[DQE_IDX_W-1:0];
	assign back_idx   = tail_idx - DQE_IDX_W'(1);
	assign prev_front = front_q - DQE_IDX_W'(1);
	assign next_front = front_q + DQE_IDX_W'(1);
	assign pos_ext    = DQE_CNT_W'(req.position);
	assign pos_idx    = front_q + DQE_IDX_W'(req.position);

	// Decode the operation
	always_comb begin
		front_d   = front_q;
		count_d   = count_q;
		rd_addr   = front_q;
		wr_addr   = tail_idx;
		wr_en     = 1'b0;
		has_value = 1'b0;
		status_d  = ST_OK;
		unique case (mode_t'(req.mode))
			MODE_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = tail_idx;
					count_d = count_q + DQE_CNT_W'(1);
				end
			end
			MODE_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = prev_front;
					front_d = prev_front;
					count_d = count_q + DQE_CNT_W'(1);
				end
			end
			MODE_POP_BACK, MODE_PEEK_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_addr   = back_idx;
					has_value = 1'b1;
					if (mode_t'(req.mode) == MODE_POP_BACK) count_d = count_q - DQE_CNT_W'(1);
				end
			end
			MODE_POP_FRONT, MODE_PEEK_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_addr   = front_q;
					has_value = 1'b1;
					if (mode_t'(req.mode) == MODE_POP_FRONT) begin
						front_d = next_front;
						count_d = count_q - DQE_CNT_W'(1);
					end
				end
			end
			MODE_READ_POS: begin
				if (pos_ext >= count_q) begin
					status_d = ST_RANGE;
				end else begin
					rd_addr   = pos_idx;
					has_value = 1'b1;
				end
			end
			MODE_CLEAR: begin
				front_d = '0;
				count_d = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (wr_en) mem[wr_addr] <= req.element;
			rd_data_q <= mem[rd_addr];
			status_q  <= status_d;
		end
	end

	// Update queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			has_value_q <= 1'b0;
		end else if (cmd.load) begin
			front_q     <= front_d;
			count_q     <= count_d;
			has_value_q <= has_value;
		end
	end

	assign rsp.value_out = has_value_q ? rd_data_q : '0;
	assign rsp.status    = status_q;
	assign rsp.occupancy = count_q;

endmodule

[rtl/core/double_ended_queue_engine.sv]
// Latency: a result is valid the cycle after its transaction is accepted.
// Flow: a new transaction is not accepted until the previous result has left,
// so any result stall holds it off; the single result register sets this.
// Reset: arst_n clears front pointer and count to an empty queue at once;
// store contents are not cleared, and unwritten entries never reach value_out.
`timescale 1ns / 1ps

module double_ended_queue_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dqe_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dqe_pkg::rsp_t rsp
);
	import dqe_pkg::*;

	dqe_cmd_t cmd;

	dqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	dqe_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[rtl/core/dqe_checker.sv]
`timescale 1ns / 1ps

module dqe_assertions (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input dqe_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input dqe_pkg::rsp_t rsp
);
	import dqe_pkg::*;

	// Every accepted transaction shows a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("no result after accepted transaction");

	// No new transaction while a result is pending
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("transaction taken while result pending");

	// Failed operations return a zero value
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> (rsp.value_out == '0))
		else $error("nonzero value with error status");

	// A dropped push means the queue is full
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> (rsp.occupancy == DQE_CNT_W'(DQE_DEPTH)))
		else $error("full status with queue not full");

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind double_ended_queue_engine dqe_assertions u_dqe_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
